// ----- rtl/core/handheld_bus_address_decoder_unit_macros.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef HANDHELD_BUS_ADDRESS_DECODER_UNIT_MACROS_SVH
`define HANDHELD_BUS_ADDRESS_DECODER_UNIT_MACROS_SVH

// Checked at every rising edge, switched off while reset is low.
`define HBAD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, also during reset.
`define HBAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/hbad_pkg.sv -----
package hbad_pkg;

    localparam int WORK_RAM_DEPTH_DEF = 8192;
    localparam int HIGH_RAM_DEPTH_DEF = 127;

    localparam logic [15:0] ADDR_CART_END   = 16'h7FFF;
    localparam logic [15:0] ADDR_ECHO_BASE  = 16'hE000;
    localparam logic [15:0] ADDR_UNUSABLE   = 16'hFEA0;
    localparam logic [15:0] ADDR_IRQ_FLAGS  = 16'hFF0F;
    localparam logic [15:0] ADDR_DMA        = 16'hFF46;
    localparam logic [15:0] ADDR_HIGH_RAM   = 16'hFF80;
    localparam logic [15:0] ADDR_IRQ_ENABLE = 16'hFFFF;

    localparam logic [7:0] READ_UNMAPPED = 8'hFF;

    typedef enum logic [2:0] {
        TGT_LOCAL  = 3'd0,
        TGT_CART   = 3'd1,
        TGT_VIDEO  = 3'd2,
        TGT_JOYPAD = 3'd3,
        TGT_SERIAL = 3'd4,
        TGT_TIMER  = 3'd5,
        TGT_DMA    = 3'd6
    } t_target;

    typedef enum logic [2:0] {
        SEL_NONE       = 3'd0,
        SEL_WORK_RAM   = 3'd1,
        SEL_HIGH_RAM   = 3'd2,
        SEL_IRQ_FLAGS  = 3'd3,
        SEL_IRQ_ENABLE = 3'd4
    } t_sel;

    typedef struct packed {
        t_target tgt;
        t_sel    sel;
    } t_dec;

endpackage

// ----- rtl/core/hbad_decode.sv -----
module hbad_decode
    import hbad_pkg::*;
(
    input  logic        i_req_type,
    input  logic [15:0] i_address,
    output t_dec        o_dec
);

    always_comb begin
        o_dec.tgt = TGT_LOCAL;
        o_dec.sel = SEL_NONE;
        if (i_address inside {[16'h0000:ADDR_CART_END], [16'hA000:16'hBFFF]}) begin
            o_dec.tgt = TGT_CART;
        end else if ((i_address inside {[16'h8000:16'h9FFF], [16'hFE00:ADDR_UNUSABLE - 16'd1],
                                        [16'hFF40:16'hFF4B]}) && (i_address != ADDR_DMA)) begin
            o_dec.tgt = TGT_VIDEO;
        end else if (i_address == 16'hFF00) begin
            o_dec.tgt = TGT_JOYPAD;
        end else if (i_address inside {[16'hFF01:16'hFF02]}) begin
            o_dec.tgt = TGT_SERIAL;
        end else if (i_address inside {[16'hFF04:16'hFF07]}) begin
            o_dec.tgt = TGT_TIMER;
        end else if ((i_address == ADDR_DMA) && i_req_type) begin
            o_dec.tgt = TGT_DMA;
        end else if (i_address inside {[16'hC000:ADDR_ECHO_BASE + 16'h1DFF]}) begin
            o_dec.sel = SEL_WORK_RAM;
        end else if (i_address inside {[ADDR_HIGH_RAM:ADDR_IRQ_ENABLE - 16'd1]}) begin
            o_dec.sel = SEL_HIGH_RAM;
        end else if (i_address == ADDR_IRQ_FLAGS) begin
            o_dec.sel = SEL_IRQ_FLAGS;
        end else if (i_address == ADDR_IRQ_ENABLE) begin
            o_dec.sel = SEL_IRQ_ENABLE;
        end
    end

endmodule

// ----- rtl/core/hbad_mem.sv -----
module hbad_mem
    import hbad_pkg::*;
#(
    parameter int WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF,
    parameter int HIGH_RAM_DEPTH = HIGH_RAM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_req_type,
    input  t_sel        i_sel,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic [7:0]  o_read_data
);

    localparam int WRAM_AW = $clog2(WORK_RAM_DEPTH);
    localparam int HRAM_AW = $clog2(HIGH_RAM_DEPTH);

    logic [7:0] r_work_ram [WORK_RAM_DEPTH];
    logic [7:0] r_high_ram [HIGH_RAM_DEPTH];
    logic [7:0] r_irq_flags;
    logic [7:0] r_irq_enable;
    logic [7:0] r_wram_q;
    logic [7:0] r_hram_q;
    logic [7:0] r_irq_q;
    t_sel       r_sel;

    logic [WRAM_AW-1:0] wram_idx;
    logic [HRAM_AW-1:0] hram_idx;
    logic               do_wr;

    assign wram_idx = i_address[WRAM_AW-1:0];
    assign hram_idx = i_address[HRAM_AW-1:0];
    assign do_wr    = i_en && i_valid && i_req_type;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (do_wr && (i_sel == SEL_WORK_RAM)) begin
                r_work_ram[wram_idx] <= i_write_data;
            end
            r_wram_q <= r_work_ram[wram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (do_wr && (i_sel == SEL_HIGH_RAM)) begin
                r_high_ram[hram_idx] <= i_write_data;
            end
            r_hram_q <= r_high_ram[hram_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_flags  <= '0;
            r_irq_enable <= '0;
        end else if (do_wr) begin
            if (i_sel == SEL_IRQ_FLAGS) begin
                r_irq_flags <= i_write_data;
            end
            if (i_sel == SEL_IRQ_ENABLE) begin
                r_irq_enable <= i_write_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= SEL_NONE;
        end else if (i_en) begin
            r_sel <= i_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_irq_q <= (i_sel == SEL_IRQ_ENABLE) ? r_irq_enable : r_irq_flags;
        end
    end

    always_comb begin
        case (r_sel)
            SEL_WORK_RAM:                  o_read_data = r_wram_q;
            SEL_HIGH_RAM:                  o_read_data = r_hram_q;
            SEL_IRQ_FLAGS, SEL_IRQ_ENABLE: o_read_data = r_irq_q;
            default:                       o_read_data = READ_UNMAPPED;
        endcase
    end

endmodule

// ----- rtl/core/handheld_bus_address_decoder_unit.sv -----
// Bus address decoder for the handheld memory map.
// Input channel: i_valid with the request word (i_req_type, i_address,
// i_write_data); the word is taken at a rising edge where i_valid is high
// and o_stall is low.
// Output channel: o_valid with the result word; it is taken at a rising edge
// where o_valid is high and i_stall is low.
// Each word is decoded and its work RAM, high RAM or interrupt byte is read
// or written in the cycle it is accepted; the result then passes through the
// stage A registers and the output registers before o_valid rises.
// Throughput is one word per cycle while the receiver does not stall, set by
// the single read or write port of each RAM, whose read data is registered.
// While the receiver stalls with a result waiting, the whole pipeline holds
// and o_stall is raised, so no word is lost or repeated.
// Reset is synchronous and active low; it empties the pipeline and clears the
// interrupt flag and enable bytes, while RAM contents stay undefined until
// written.
module handheld_bus_address_decoder_unit
    import hbad_pkg::*;
#(
    parameter int WORK_RAM_DEPTH = WORK_RAM_DEPTH_DEF,
    parameter int HIGH_RAM_DEPTH = HIGH_RAM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_target,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_forward_address,
    output logic [7:0]  o_forward_data,
    output logic        o_forward_write
);

    t_dec        dec;
    logic        advance;
    logic [7:0]  mem_rdata;

    logic        r_a_valid;
    t_target     r_a_tgt;
    logic        r_a_wr;
    logic [15:0] r_a_addr;
    logic [7:0]  r_a_wdata;

    logic        r_out_valid;
    t_target     r_tgt;
    logic [7:0]  r_rdata;
    logic [15:0] r_faddr;
    logic [7:0]  r_fdata;
    logic        r_fwr;

    logic        n_local;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = !advance;

    hbad_decode u_decode (
        .i_req_type (i_req_type),
        .i_address  (i_address),
        .o_dec      (dec)
    );

    hbad_mem #(
        .WORK_RAM_DEPTH (WORK_RAM_DEPTH),
        .HIGH_RAM_DEPTH (HIGH_RAM_DEPTH)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_valid      (i_valid),
        .i_req_type   (i_req_type),
        .i_sel        (dec.sel),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_read_data  (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid   <= i_valid;
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_tgt   <= dec.tgt;
            r_a_wr    <= i_req_type;
            r_a_addr  <= i_address;
            r_a_wdata <= i_write_data;
        end
    end

    assign n_local = (r_a_tgt == TGT_LOCAL);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tgt   <= r_a_tgt;
            r_rdata <= (n_local && !r_a_wr) ? mem_rdata : 8'h00;
            r_faddr <= n_local ? 16'h0000 : r_a_addr;
            r_fdata <= (!n_local && r_a_wr) ? r_a_wdata : 8'h00;
            r_fwr   <= !n_local && r_a_wr;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_target          = r_tgt;
    assign o_read_data       = r_rdata;
    assign o_forward_address = r_faddr;
    assign o_forward_data    = r_fdata;
    assign o_forward_write   = r_fwr;

    `include "handheld_bus_address_decoder_unit_macros.svh"

    `HBAD_ASSERT(a_stall_only_when_full, i_clk, i_rst_n,
        o_stall |-> (o_valid && i_stall), "Input stalled without a waiting result")
    `HBAD_ASSERT(a_accept_reaches_stage, i_clk, i_rst_n,
        (i_valid && !o_stall) |=> r_a_valid, "Accepted word did not enter the pipeline")
    `HBAD_ASSERT(a_forward_no_read, i_clk, i_rst_n,
        (o_valid && (o_target != TGT_LOCAL)) |-> (o_read_data == 8'h00),
        "Forwarded access carries read data")
    `HBAD_ASSERT(a_write_is_forwarded, i_clk, i_rst_n,
        (o_valid && o_forward_write) |-> (o_target != TGT_LOCAL),
        "Local access marked as forwarded write")
    `HBAD_ASSERT(a_dma_start_form, i_clk, i_rst_n,
        (o_valid && (o_target == TGT_DMA)) |->
        (o_forward_write && (o_forward_address == ADDR_DMA)), "Malformed DMA start")
    `HBAD_ASSERT_ALWAYS(a_reset_empties, i_clk,
        !i_rst_n |=> (!o_valid && !r_a_valid), "Pipeline not empty after reset")

endmodule
